FILE: src/bsa_pkg.sv
// Shared constants, codes and helper functions for the bitmap slot allocator.
// No dependencies; every other file in src refers to this package by scoped names.
`default_nettype none
package bsa_pkg;

	localparam int SLOT_COUNT   = 256;
	localparam int SLOT_BYTES   = 16;
	localparam int HEADER_BYTES = 32;
	localparam int PAGE_BYTES   = 4096;

	localparam int WORD_BITS  = 32;
	localparam int WORD_COUNT = SLOT_COUNT / WORD_BITS;
	localparam int WORD_AW    = $clog2(WORD_COUNT);
	localparam int BIT_AW     = $clog2(WORD_BITS);
	localparam int SLOT_AW    = $clog2(SLOT_COUNT);
	localparam int SLOT_SHIFT = $clog2(SLOT_BYTES);
	localparam int PAGE_AW    = $clog2(PAGE_BYTES);

	localparam int FUNC_W  = 2;
	localparam int REQ_W   = 8;
	localparam int FOFF_W  = 20;
	localparam int BOFF_W  = 13;
	localparam int AVAIL_W = 21;
	localparam int POOL_W  = 21;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

	// register index = paddr[2]
	localparam logic REG_POOL_SIZE = 1'b0;

	localparam logic [POOL_W-1:0] POOL_MAX   = 21'd1048576;
	localparam logic [POOL_W-1:0] POOL_RESET = 21'd4096;

	// free byte count after (re)initialization with a given requested pool size
	function automatic logic signed [AVAIL_W-1:0] pool_avail(input logic [POOL_W-1:0] sz);
		logic [POOL_W-1:0] s;
		logic [POOL_W:0]   r;
		s = sz;
		if (s == '0)
			s = POOL_W'(1);
		if (s > POOL_MAX)
			s = POOL_MAX;
		r = (POOL_W+1)'(s) + (POOL_W+1)'(PAGE_BYTES - 1);
		r[PAGE_AW-1:0] = '0;
		return signed'(POOL_W'(r) - AVAIL_W'(HEADER_BYTES));
	endfunction

	// index of the lowest clear bit; caller checks the word is not all ones
	function automatic logic [BIT_AW-1:0] first_zero(input logic [WORD_BITS-1:0] w);
		logic [BIT_AW-1:0] idx;
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!w[i])
				idx = BIT_AW'(i);
		end
		return idx;
	endfunction

endpackage
`default_nettype wire

FILE: src/bsa_chan_if.sv
// Valid/ready channel interfaces for the allocator command and response.
// Depends on bsa_pkg for the field widths.
`default_nettype none
interface bsa_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [bsa_pkg::FUNC_W-1:0]   func;
	logic [bsa_pkg::REQ_W-1:0]    request_bytes;
	logic                         pointer_null;
	logic [bsa_pkg::FOFF_W-1:0]   free_offset;

	modport source (output valid, func, request_bytes, pointer_null, free_offset,
		input ready);
	modport sink (input valid, func, request_bytes, pointer_null, free_offset,
		output ready);
endinterface

interface bsa_rsp_if;
	logic                                valid;
	logic                                ready;
	logic                                status;
	logic [bsa_pkg::BOFF_W-1:0]          block_offset;
	logic signed [bsa_pkg::AVAIL_W-1:0]  available_bytes;

	modport source (output valid, status, block_offset, available_bytes, input ready);
	modport sink (input valid, status, block_offset, available_bytes, output ready);
endinterface
`default_nettype wire

FILE: src/bitmap_slot_allocator.sv
// Bitmap slot allocator: one transaction in, one response out, in order. The in-use
// bitmap sits in an 8 x 32-bit synchronous memory, and the first-free search reads
// one word per cycle from word 0 until it finds a free slot or has read the last word;
// a free reads, modifies and writes back its word, while a query or a rejected
// command goes straight to the response. A finished response waits in an output
// register, so a new command is taken while the previous response is still unclaimed.
// Writing pool_size (APB, address 0) reinitializes the pool: per-word valid flags
// clear the whole bitmap at once, no sweep is needed.
// Depends on bsa_pkg and the interfaces in bsa_chan_if.sv.
`default_nettype none
module bitmap_slot_allocator (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	bsa_cmd_if.sink                            cmd,
	bsa_rsp_if.source                          rsp,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [bsa_pkg::APB_AW-1:0]    paddr,
	input  wire logic [bsa_pkg::APB_DW-1:0]    pwdata,
	output logic      [bsa_pkg::APB_DW-1:0]    prdata,
	output logic                               pready
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FREE = 2'd2;
	localparam logic [1:0] ST_OUTW = 2'd3;

	localparam int WA = bsa_pkg::WORD_AW;
	localparam int BA = bsa_pkg::BIT_AW;
	localparam int WB = bsa_pkg::WORD_BITS;

	logic [1:0]                          state_q;
	logic [bsa_pkg::POOL_W-1:0]          pool_size_q;
	logic signed [bsa_pkg::AVAIL_W-1:0]  free_bytes_q;
	logic [bsa_pkg::WORD_COUNT-1:0]      row_vld_q;
	logic [WA-1:0]                       widx_q;
	logic [BA-1:0]                       bit_q;
	logic                                pend_status_q;
	logic [bsa_pkg::BOFF_W-1:0]          pend_blk_q;
	logic                                out_valid_q;
	logic                                out_status_q;
	logic [bsa_pkg::BOFF_W-1:0]          out_blk_q;
	logic signed [bsa_pkg::AVAIL_W-1:0]  out_avail_q;

	logic [WB-1:0] mem [bsa_pkg::WORD_COUNT];
	logic [WB-1:0] rd_data_q;
	logic [WA-1:0] rd_addr;
	logic          mem_we;
	logic [WB-1:0] mem_wdata;

	logic                           cmd_fire;
	logic                           cfg_we;
	logic                           alloc_ok;
	logic                           free_ok;
	logic [bsa_pkg::FOFF_W-1:0]     rel;
	logic [bsa_pkg::SLOT_AW-1:0]    free_slot;
	logic [WB-1:0]                  word;
	logic                           word_full;
	logic [BA-1:0]                  zero_bit;
	logic                           alloc_hit;
	logic                           out_load;

	assign cmd_fire  = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == ST_IDLE);
	assign cfg_we    = psel && penable && pwrite && (paddr[2] == bsa_pkg::REG_POOL_SIZE);
	assign pready    = 1'b1;
	assign prdata    = (paddr[2] == bsa_pkg::REG_POOL_SIZE) ?
		bsa_pkg::APB_DW'(pool_size_q) : '0;

	// command decode
	assign alloc_ok = (cmd.func == bsa_pkg::FUNC_ALLOC) && (cmd.request_bytes != '0)
		&& (cmd.request_bytes <= bsa_pkg::REQ_W'(bsa_pkg::SLOT_BYTES))
		&& (free_bytes_q >= $signed({{(bsa_pkg::AVAIL_W-bsa_pkg::REQ_W){1'b0}},
			cmd.request_bytes}));
	assign rel       = cmd.free_offset - bsa_pkg::FOFF_W'(bsa_pkg::HEADER_BYTES);
	assign free_slot = rel[bsa_pkg::SLOT_SHIFT +: bsa_pkg::SLOT_AW];
	assign free_ok   = (cmd.func == bsa_pkg::FUNC_FREE) && !cmd.pointer_null
		&& (cmd.free_offset >= bsa_pkg::FOFF_W'(bsa_pkg::HEADER_BYTES))
		&& (rel[bsa_pkg::SLOT_SHIFT-1:0] == '0)
		&& (rel[bsa_pkg::FOFF_W-1:bsa_pkg::SLOT_SHIFT+bsa_pkg::SLOT_AW] == '0);

	// words never written since init read as all free
	assign word      = row_vld_q[widx_q] ? rd_data_q : '0;
	assign word_full = &word;
	assign zero_bit  = bsa_pkg::first_zero(word);
	assign alloc_hit = (state_q == ST_SCAN) && !word_full;

	always_comb begin
		rd_addr = widx_q + WA'(1);
		if (state_q == ST_IDLE)
			rd_addr = alloc_ok ? '0 : free_slot[bsa_pkg::SLOT_AW-1:BA];
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = word;
		if (alloc_hit) begin
			mem_we    = 1'b1;
			mem_wdata = word | (WB'(1) << zero_bit);
		end else if (state_q == ST_FREE) begin
			mem_we    = 1'b1;
			mem_wdata = word & ~(WB'(1) << bit_q);
		end
	end

	// one access at a time: the write lands before the next transaction's read
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[widx_q] <= mem_wdata;
		rd_data_q <= mem[rd_addr];
	end

	assign out_load = (state_q == ST_OUTW) && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pool_size_q  <= bsa_pkg::POOL_RESET;
			free_bytes_q <= bsa_pkg::pool_avail(bsa_pkg::POOL_RESET);
			row_vld_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				pool_size_q  <= pwdata[bsa_pkg::POOL_W-1:0];
				free_bytes_q <= bsa_pkg::pool_avail(pwdata[bsa_pkg::POOL_W-1:0]);
				row_vld_q    <= '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						if (alloc_ok)
							state_q <= ST_SCAN;
						else if (free_ok)
							state_q <= ST_FREE;
						else
							state_q <= ST_OUTW;
					end
				end
				ST_SCAN: begin
					if (!word_full) begin
						row_vld_q[widx_q] <= 1'b1;
						free_bytes_q <= free_bytes_q - bsa_pkg::AVAIL_W'(bsa_pkg::SLOT_BYTES);
						state_q <= ST_OUTW;
					end else if (widx_q == WA'(bsa_pkg::WORD_COUNT - 1)) begin
						state_q <= ST_OUTW;
					end
				end
				ST_FREE: begin
					row_vld_q[widx_q] <= 1'b1;
					state_q <= ST_OUTW;
				end
				ST_OUTW: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (out_load)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				widx_q        <= alloc_ok ? '0 : free_slot[bsa_pkg::SLOT_AW-1:BA];
				bit_q         <= free_slot[BA-1:0];
				pend_status_q <= !(free_ok || (cmd.func == bsa_pkg::FUNC_QUERY));
				pend_blk_q    <= '0;
			end
			ST_SCAN: begin
				if (!word_full) begin
					pend_status_q <= 1'b0;
					pend_blk_q    <= bsa_pkg::BOFF_W'(bsa_pkg::HEADER_BYTES)
						+ bsa_pkg::BOFF_W'({widx_q, zero_bit, {bsa_pkg::SLOT_SHIFT{1'b0}}});
				end else begin
					pend_status_q <= 1'b1;
					widx_q        <= widx_q + WA'(1);
				end
			end
			ST_FREE: pend_status_q <= 1'b0;
			ST_OUTW: begin
				if (out_load) begin
					out_status_q <= pend_status_q;
					out_blk_q    <= pend_blk_q;
					out_avail_q  <= free_bytes_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.status          = out_status_q;
	assign rsp.block_offset    = out_blk_q;
	assign rsp.available_bytes = out_avail_q;

`ifndef SYNTH
	a_scan_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (free_bytes_q > 0))
		else $error("search running with no bytes left");
	a_fire_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire |=> (state_q != ST_IDLE))
		else $error("accepted transaction dropped");
	a_free_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FREE) |-> ($past(state_q) == ST_IDLE))
		else $error("free write-back without a read");
	a_write_marks_row: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && !cfg_we) |=> row_vld_q[$past(widx_q)])
		else $error("written word not marked valid");
	a_bytes_only_change: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(free_bytes_q) |-> ($past(cfg_we) || $past(alloc_hit)))
		else $error("free byte count changed without allocate or init");
`endif

endmodule
`default_nettype wire
